/* hdl/ial_pkg.sv */
// Package for the indexed array list: sizes, operation and status codes,
// and the control bundle that the top level hands to every storage cell.
// Used by ial_cell and indexed_array_list; depends on nothing.
package ial_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 7;
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;

  typedef enum logic [FUNC_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_ERASE  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell; at most one of wr, ins and ers is set.
  typedef struct packed {
    logic              wr;
    logic              ins;
    logic              ers;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

/* hdl/ial_cell.sv */
// One storage cell of the indexed array list: holds a single entry and
// takes its neighbour's entry when the list shifts. Depends on ial_pkg.
module ial_cell (
  input  logic                       clk,
  input  ial_pkg::cell_ctl_t         ctl,
  input  logic [ial_pkg::POS_W-1:0]  cell_idx,
  input  logic [ial_pkg::DATA_W-1:0] from_lower,
  input  logic [ial_pkg::DATA_W-1:0] from_upper,
  output logic [ial_pkg::DATA_W-1:0] entry,
  output logic [ial_pkg::DATA_W-1:0] rd_word
);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (cell_idx == ctl.pos);
  assign above_pos = (cell_idx > ctl.pos);

  // Only the addressed cell puts its entry on the read bus.
  assign rd_word = at_pos ? entry : '0;

  always_ff @(posedge clk) begin
    if ((ctl.wr || ctl.ins) && at_pos) begin
      entry <= ctl.value;
    end else if (ctl.ins && above_pos) begin
      entry <= from_lower;
    end else if (ctl.ers && (at_pos || above_pos)) begin
      entry <= from_upper;
    end
  end

endmodule

/* hdl/indexed_array_list.sv */
// Top level of the indexed array list: handshake, bounds checks, element
// count and the row of ial_cell storage cells. Depends on ial_pkg, ial_cell.
//
// Usage:
//   Each transaction on the s_axis channel carries an operation (read,
//   write, insert or erase), an index and a value. Every transaction gives
//   exactly one result transaction on m_axis: the data read or written,
//   a status (ok, index out of range, list full), the element count after
//   the operation and an empty flag.
//   Insert moves all later entries up by one and erase moves them down by
//   one; every cell of the row shifts in the same cycle, whatever the index.
//   The result is registered and valid in the cycle after acceptance. The
//   result sits in a single output register; a new transaction is accepted
//   in the cycle that register is empty or being taken, so throughput is
//   one transaction per cycle while the receiver keeps up.
//   When the receiver stalls, the result is held and s_axis_tready drops
//   until it is taken.
//   Reset (rst, synchronous, active high) empties the list and the output
//   register. Stored entries are not cleared; only positions below the
//   count are ever read.
module indexed_array_list (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [1:0] func, [8:2] index, [40:9] value, [47:41] zero
  input  logic [ial_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [31:0] data, [33:32] status, [40:34] count, [41] is_empty, [47:42] zero
  output logic [ial_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int CAP = ial_pkg::CAPACITY;

  ial_pkg::op_t                 op;
  logic [ial_pkg::IDX_W-1:0]    index;
  logic [ial_pkg::DATA_W-1:0]   value;
  logic                         accept;
  logic                         idx_in_list;
  logic                         ok;
  ial_pkg::status_t             status_next;
  logic [ial_pkg::DATA_W-1:0]   data_next;
  logic [ial_pkg::CNT_W-1:0]    fill_count;
  logic [ial_pkg::CNT_W-1:0]    fill_count_next;
  ial_pkg::cell_ctl_t           ctl;
  logic [ial_pkg::DATA_W-1:0]   entry   [CAP];
  logic [ial_pkg::DATA_W-1:0]   rd_word [CAP];
  logic [ial_pkg::DATA_W-1:0]   rd_data;

  logic [ial_pkg::DATA_W-1:0]   out_data;
  ial_pkg::status_t             out_status;
  logic [ial_pkg::CNT_W-1:0]    out_count;
  logic                         out_valid;

  assign op    = ial_pkg::op_t'(s_axis_tdata[1:0]);
  assign index = s_axis_tdata[8:2];
  assign value = s_axis_tdata[40:9];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign idx_in_list = ({1'b0, index} < {1'b0, fill_count});

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAP; i++) begin
      rd_data = rd_data | rd_word[i];
    end
  end

  always_comb begin
    ok              = 1'b0;
    status_next     = ial_pkg::ST_OK;
    data_next       = '0;
    fill_count_next = fill_count;
    case (op)
      ial_pkg::OP_READ: begin
        ok = idx_in_list;
        if (ok) data_next = rd_data;
      end
      ial_pkg::OP_WRITE: begin
        ok = idx_in_list;
        if (ok) data_next = value;
      end
      ial_pkg::OP_INSERT: begin
        if (fill_count == ial_pkg::CNT_W'(CAP)) begin
          status_next = ial_pkg::ST_FULL;
        end else begin
          ok = (index <= fill_count);
          if (ok) begin
            data_next       = value;
            fill_count_next = fill_count + 1'b1;
          end
        end
      end
      ial_pkg::OP_ERASE: begin
        ok = idx_in_list;
        if (ok) fill_count_next = fill_count - 1'b1;
      end
      default: ok = 1'b0;
    endcase
    if (!ok && status_next == ial_pkg::ST_OK) status_next = ial_pkg::ST_RANGE;
  end

  always_comb begin
    ctl.wr    = accept && ok && (op == ial_pkg::OP_WRITE);
    ctl.ins   = accept && ok && (op == ial_pkg::OP_INSERT);
    ctl.ers   = accept && ok && (op == ial_pkg::OP_ERASE);
    ctl.pos   = index[ial_pkg::POS_W-1:0];
    ctl.value = value;
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [ial_pkg::DATA_W-1:0] lower;
    logic [ial_pkg::DATA_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = value;
    end else begin : g_mid_lo
      assign lower = entry[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign upper = entry[i];
    end else begin : g_mid_hi
      assign upper = entry[i+1];
    end
    ial_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_idx   (ial_pkg::POS_W'(i)),
      .from_lower (lower),
      .from_upper (upper),
      .entry      (entry[i]),
      .rd_word    (rd_word[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
        out_valid  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data   <= data_next;
      out_status <= status_next;
      out_count  <= fill_count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, (out_count == '0), out_count, out_status, out_data};

  // The list never holds more entries than there are cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= ial_pkg::CNT_W'(CAP))
    else $error("element count above capacity");

  // A successful insert adds exactly one element.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> fill_count == $past(fill_count) + 1'b1)
    else $error("insert did not grow the list by one");

  // A refused operation reports zero data and leaves the count alone.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (accept && !ok) |=> (out_data == '0) && (fill_count == $past(fill_count)))
    else $error("refused operation changed state or returned data");

  // After an accepted operation, the reported count matches the list's own count.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_count == fill_count)
    else $error("result count differs from the element count");

endmodule
